FILE: rtl/core/tape_machine_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// Tape machine execute unit assertion macros
// Shared helpers for the concurrent checks of the execute unit.
// ----------------------------------------------------------------------------
`ifndef TAPE_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define TAPE_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TME_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tape machine execute unit check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tape machine execute unit check failed");

`endif

FILE: rtl/core/tme_pkg.sv
// ----------------------------------------------------------------------------
// Tape machine execute unit package
// Operation codes and the structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package tme_pkg;

	typedef enum logic [2:0] {
		OP_ADD_BYTE = 3'd0,
		OP_SUB_BYTE = 3'd1,
		OP_PTR_UP   = 3'd2,
		OP_PTR_DOWN = 3'd3,
		OP_WRITE    = 3'd4,
		OP_READ     = 3'd5,
		OP_JUMP_Z   = 3'd6,
		OP_JUMP     = 3'd7
	} op_t;

	localparam logic [7:0] EOF_BYTE = 8'hFF;

	// The program depth is at least 256, so a jump quotient fits in eight bits.
	localparam int JQ_W = 8;

	typedef struct packed {
		op_t             op;
		logic [7:0]      delta;
		logic [7:0]      in_data;
		logic            eof;
		logic [15:0]     target;
		logic [JQ_W-1:0] jq;
		logic            cell_ok;
		logic            range_err;
	} s1_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  data;
	} wr_t;

	typedef struct packed {
		logic [15:0] next_ip;
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        range_error;
		logic        read_error;
	} res_t;

endpackage

FILE: rtl/core/tme_tape_ram.sv
// ----------------------------------------------------------------------------
// Tape memory
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tme_tape_ram #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/tme_front.sv
// ----------------------------------------------------------------------------
// Tape machine front stage
// Holds the data pointer, forms the tape read address and range flags, and
// starts the reduction of the jump target.
// ----------------------------------------------------------------------------
module tme_front import tme_pkg::*; #(
	parameter int TAPE_DEPTH    = 32768,
	parameter int PROGRAM_DEPTH = 65536,
	parameter int AW            = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [2:0]    req_type,
	input  logic [15:0]   amount,
	input  logic [15:0]   jump_target,
	input  logic [7:0]    input_byte,
	input  logic          input_eof,
	output logic [AW-1:0] raddr,
	output s1_t           item
);

	localparam logic [16:0] TAPE_LIMIT = 17'(TAPE_DEPTH);
	localparam logic [24:0] RECIP      = 25'(((64'd1 << 32) + 64'(PROGRAM_DEPTH) - 64'd1)
		/ 64'(PROGRAM_DEPTH));

	logic [15:0] dp_q;
	logic [15:0] dp_next;
	logic [40:0] prod;
	op_t         op;

	assign op = op_t'(req_type);

	always_comb begin
		dp_next = dp_q;
		unique case (op)
			OP_PTR_UP:   dp_next = dp_q + amount;
			OP_PTR_DOWN: dp_next = dp_q - amount;
			default:     dp_next = dp_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dp_q <= '0;
		end else if (accept) begin
			dp_q <= dp_next;
		end
	end

	assign prod  = {25'd0, jump_target} * {16'd0, RECIP};
	assign raddr = dp_q[AW-1:0];

	always_comb begin
		item.op        = op;
		item.delta     = amount[7:0];
		item.in_data   = input_byte;
		item.eof       = input_eof;
		item.target    = jump_target;
		item.jq        = prod[32 +: JQ_W];
		item.cell_ok   = {1'b0, dp_q} < TAPE_LIMIT;
		item.range_err = {1'b0, dp_next} >= TAPE_LIMIT;
	end

endmodule

FILE: rtl/core/tme_exec.sv
// ----------------------------------------------------------------------------
// Tape machine execute stage
// Applies the operation to the fetched cell, forms the tape write-back and the
// result, and keeps the instruction pointer.
// ----------------------------------------------------------------------------
module tme_exec import tme_pkg::*; #(
	parameter int PROGRAM_DEPTH = 65536
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  s1_t        item,
	input  logic [7:0] cell_raw,
	output res_t       result,
	output wr_t        wr
);

	localparam logic [16:0] PD = 17'(PROGRAM_DEPTH);

	logic [15:0] ip_q;
	logic [7:0]  cell_val;
	logic [16:0] seq_sum;
	logic [15:0] seq;
	logic [16:0] qpd;
	logic [16:0] rem;
	logic [15:0] tmod;
	logic        take;

	assign cell_val = item.cell_ok ? cell_raw : 8'd0;
	assign seq_sum  = {1'b0, ip_q} + 17'd1;
	assign seq      = (seq_sum == PD) ? 16'd0 : seq_sum[15:0];
	assign qpd      = 17'({9'd0, item.jq} * PD);
	assign rem      = {1'b0, item.target} - qpd;
	assign tmod     = (rem >= PD) ? 16'(rem - PD) : rem[15:0];

	always_comb begin
		take               = 1'b0;
		wr.en              = 1'b0;
		wr.data            = cell_val;
		result.out_valid   = 1'b0;
		result.out_byte    = 8'd0;
		result.read_error  = 1'b0;
		result.range_error = item.range_err;
		unique case (item.op)
			OP_ADD_BYTE: begin
				wr.en   = item.cell_ok;
				wr.data = cell_val + item.delta;
			end
			OP_SUB_BYTE: begin
				wr.en   = item.cell_ok;
				wr.data = cell_val - item.delta;
			end
			OP_WRITE: begin
				result.out_valid = 1'b1;
				result.out_byte  = cell_val;
			end
			OP_READ: begin
				wr.en             = item.cell_ok;
				wr.data           = item.eof ? EOF_BYTE : item.in_data;
				result.read_error = item.eof;
			end
			OP_JUMP_Z: take = (cell_val == 8'd0);
			OP_JUMP:   take = 1'b1;
			default:   take = 1'b0;
		endcase
		result.next_ip = take ? tmod : seq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q <= '0;
		end else if (adv) begin
			ip_q <= result.next_ip;
		end
	end

endmodule

FILE: rtl/core/tape_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// Tape machine execute unit
// Runs one compiled tape-machine instruction per item over a byte tape held in
// a synchronous RAM.
// ----------------------------------------------------------------------------
// The unit takes one item per cycle while req_stall is low. An accepted item
// reads its tape cell at the accept edge and waits in the execute stage; when
// that stage advances, the cell is modified and written back and the result is
// loaded into the output register, which offers it on rsp_valid. While a
// result waits on rsp_stall the item behind it, if any, holds and req_stall
// stays high. A write-back that hits the cell read by the following item is
// forwarded, so back-to-back updates of one cell run at full rate. After reset
// the tape is cleared one cell per cycle, from the first cell to the last, and
// req_stall stays high until that sweep is done.
`include "tape_machine_execute_unit_defines.svh"

module tape_machine_execute_unit import tme_pkg::*; #(
	parameter int TAPE_DEPTH    = 32768,
	parameter int PROGRAM_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] amount,
	input  logic [15:0] jump_target,
	input  logic [7:0]  input_byte,
	input  logic        input_eof,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [15:0] next_ip,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        range_error,
	output logic        read_error
);

	localparam int          AW   = $clog2(TAPE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(TAPE_DEPTH - 1);

	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          accept;
	logic          s1_adv;
	logic          s1_valid_q;
	s1_t           item_s1;
	logic [AW-1:0] addr_s1;
	logic          fwd_s1;
	logic [7:0]    fwd_data_s1;
	s1_t           item;
	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [7:0]    cell_raw;
	res_t          result;
	wr_t           wr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          fwd_hit;
	logic          rsp_valid_q;
	res_t          res_q;

	assign s1_adv    = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clearing_q || (s1_valid_q && !s1_adv);
	assign accept    = req_valid && !req_stall;

	assign mem_we    = clearing_q || (wr.en && s1_adv);
	assign mem_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign mem_wdata = clearing_q ? 8'd0 : wr.data;
	assign fwd_hit   = wr.en && s1_adv && (addr_s1 == raddr);
	assign cell_raw  = fwd_s1 ? fwd_data_s1 : rdata;

	tme_front #(
		.TAPE_DEPTH    (TAPE_DEPTH),
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.AW            (AW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.req_type    (req_type),
		.amount      (amount),
		.jump_target (jump_target),
		.input_byte  (input_byte),
		.input_eof   (input_eof),
		.raddr       (raddr),
		.item        (item)
	);

	tme_tape_ram #(
		.DEPTH (TAPE_DEPTH),
		.AW    (AW)
	) u_tape (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (raddr),
		.rdata (rdata)
	);

	tme_exec #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (s1_adv),
		.item     (item_s1),
		.cell_raw (cell_raw),
		.result   (result),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			addr_s1     <= raddr;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= wr.data;
		end
		if (s1_adv) begin
			res_q <= result;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign next_ip     = res_q.next_ip;
	assign out_valid   = res_q.out_valid;
	assign out_byte    = res_q.out_byte;
	assign range_error = res_q.range_error;
	assign read_error  = res_q.read_error;

	`TME_ASSERT_NOW(a_no_accept_in_clear, clk, arst_n, clearing_q, !accept)
	`TME_ASSERT_NEXT(a_s1_holds, clk, arst_n, s1_valid_q && !s1_adv,
		s1_valid_q && $stable(addr_s1))
	`TME_ASSERT_NOW(a_byte_only_on_write, clk, arst_n, rsp_valid_q && !res_q.out_valid,
		res_q.out_byte == 8'd0)
	`TME_ASSERT_NOW(a_clear_ends_at_last, clk, arst_n, $fell(clearing_q),
		$past(clr_addr_q) == LAST)

endmodule

FILE: dv/tme_checker.sv
// ----------------------------------------------------------------------------
// Tape machine execute unit checker
// Watches both channels of the execute unit. It runs each accepted instruction
// on its own copy of the tape and pointers, queues the expected result, and
// compares every accepted result with the oldest queued one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tme_checker import tme_pkg::*; #(
	parameter int TAPE_DEPTH    = 32768,
	parameter int PROGRAM_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] amount,
	input  logic [15:0] jump_target,
	input  logic [7:0]  input_byte,
	input  logic        input_eof,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [15:0] next_ip,
	input  logic        out_valid,
	input  logic [7:0]  out_byte,
	input  logic        range_error,
	input  logic        read_error,
	output int          mismatches,
	output int          outstanding
);

	logic [7:0]  cells [TAPE_DEPTH];
	logic [15:0] data_ptr;
	logic [15:0] instr_ptr;
	res_t        results_q [$];
	int          bad_count = 0;

	assign mismatches  = bad_count;
	assign outstanding = results_q.size();

	function automatic res_t run_instr(op_t op, logic [15:0] amt, logic [15:0] tgt,
			logic [7:0] din, logic eof);
		res_t        r;
		logic        hit;
		logic [7:0]  cell_val;
		logic [15:0] nip;
		r        = '0;
		hit      = int'(data_ptr) < TAPE_DEPTH;
		cell_val = hit ? cells[data_ptr] : 8'h00;
		nip      = 16'((int'(instr_ptr) + 1) % PROGRAM_DEPTH);
		case (op)
			OP_ADD_BYTE: begin
				if (hit)
					cells[data_ptr] = cell_val + amt[7:0];
			end
			OP_SUB_BYTE: begin
				if (hit)
					cells[data_ptr] = cell_val - amt[7:0];
			end
			OP_PTR_UP:   data_ptr = data_ptr + amt;
			OP_PTR_DOWN: data_ptr = data_ptr - amt;
			OP_WRITE: begin
				r.out_valid = 1'b1;
				r.out_byte  = cell_val;
			end
			OP_READ: begin
				r.read_error = eof;
				if (hit)
					cells[data_ptr] = eof ? EOF_BYTE : din;
			end
			OP_JUMP_Z: begin
				if (cell_val == 8'h00)
					nip = 16'(int'(tgt) % PROGRAM_DEPTH);
			end
			default:     nip = 16'(int'(tgt) % PROGRAM_DEPTH);
		endcase
		instr_ptr     = nip;
		r.next_ip     = nip;
		r.range_error = !(int'(data_ptr) < TAPE_DEPTH);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			for (int i = 0; i < TAPE_DEPTH; i++)
				cells[i] = 8'h00;
			data_ptr  = '0;
			instr_ptr = '0;
			results_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got = {next_ip, out_valid, out_byte, range_error, read_error};
				if (results_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: unexpected result ip=%h ov=%b ob=%h re=%b rd=%b",
							$time, got.next_ip, got.out_valid, got.out_byte,
							got.range_error, got.read_error);
				end else begin
					want = results_q.pop_front();
					if (got.next_ip !== want.next_ip || got.out_valid !== want.out_valid ||
							got.out_byte !== want.out_byte ||
							got.range_error !== want.range_error ||
							got.read_error !== want.read_error) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("%0t: result mismatch", $time);
							$display("  expected ip=%h ov=%b ob=%h re=%b rd=%b",
								want.next_ip, want.out_valid, want.out_byte,
								want.range_error, want.read_error);
							$display("  actual   ip=%h ov=%b ob=%h re=%b rd=%b",
								got.next_ip, got.out_valid, got.out_byte,
								got.range_error, got.read_error);
						end
					end
				end
			end
			if (req_valid && !req_stall)
				results_q.push_back(run_instr(op_t'(req_type), amount, jump_target,
					input_byte, input_eof));
		end
	end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Tape machine execute unit testbench
// Resets the unit, waits out the tape clear, then sends a directed program over
// the byte and pointer extremes, the out-of-range pointer, end of input and the
// jumps, then random instructions that mostly step the pointer a little or back
// to low cells. Both sides add random gaps; a separate checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import tme_pkg::*;

	localparam int TAPE_DEPTH    = 32768;
	localparam int PROGRAM_DEPTH = 65536;
	localparam int RANDOM_ITEMS  = 1600;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	op_t         req_type;
	logic [15:0] amount;
	logic [15:0] jump_target;
	logic [7:0]  input_byte;
	logic        input_eof;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [15:0] next_ip;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        range_error;
	logic        read_error;
	int          mismatches;
	int          outstanding;
	logic        calm = 1'b1;
	logic [15:0] ptr_shadow = '0;

	tape_machine_execute_unit #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.PROGRAM_DEPTH(PROGRAM_DEPTH)
	) dut (.*);

	tme_checker #(
		.TAPE_DEPTH(TAPE_DEPTH),
		.PROGRAM_DEPTH(PROGRAM_DEPTH)
	) checker_i (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic issue(op_t op, logic [15:0] amt, logic [15:0] tgt, logic [7:0] din,
			logic eof);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= op;
		amount      <= amt;
		jump_target <= tgt;
		input_byte  <= din;
		input_eof   <= eof;
		do @(posedge clk); while (req_stall);
		if (op == OP_PTR_UP)
			ptr_shadow = ptr_shadow + amt;
		else if (op == OP_PTR_DOWN)
			ptr_shadow = ptr_shadow - amt;
	endtask

	task automatic random_instr();
		op_t         op;
		logic [15:0] amt;
		logic [15:0] spot;
		int          r;
		op   = op_t'($urandom_range(0, 7));
		amt  = 16'($urandom());
		r    = $urandom_range(0, 99);
		spot = 16'($urandom_range(0, 15));
		if (op == OP_PTR_UP || op == OP_PTR_DOWN) begin
			if ((int'(ptr_shadow) >= TAPE_DEPTH && r < 60) || r < 8)
				amt = (op == OP_PTR_UP) ? spot - ptr_shadow : ptr_shadow - spot;
			else if (r < 85)
				amt = 16'($urandom_range(0, 3));
		end
		issue(op, amt, 16'($urandom()), 8'($urandom()), $urandom_range(0, 4) == 0);
	endtask

	initial begin
		int hold;
		forever begin
			hold = calm ? 0 : $urandom_range(0, 10);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin
		arst_n      <= 1'b0;
		req_valid   <= 1'b0;
		req_type    <= OP_ADD_BYTE;
		amount      <= '0;
		jump_target <= '0;
		input_byte  <= '0;
		input_eof   <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_JUMP_Z,   16'h0000, 16'hFFFF, 8'h00, 1'b0);
		issue(OP_ADD_BYTE, 16'hFFFF, 16'h0000, 8'h00, 1'b0);
		issue(OP_ADD_BYTE, 16'h0001, 16'h0000, 8'h00, 1'b0);
		issue(OP_SUB_BYTE, 16'hFF01, 16'h0000, 8'h00, 1'b0);
		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_JUMP_Z,   16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_READ,     16'h0000, 16'h0000, 8'hA5, 1'b0);
		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_READ,     16'h0000, 16'h0000, 8'h3C, 1'b1);
		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_JUMP,     16'hFFFF, 16'hAAAA, 8'hFF, 1'b0);
		issue(OP_JUMP,     16'h0000, 16'h5555, 8'h00, 1'b0);
		issue(OP_PTR_DOWN, 16'h0001, 16'h0000, 8'h00, 1'b0);
		issue(OP_ADD_BYTE, 16'h0005, 16'h0000, 8'h00, 1'b0);
		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_READ,     16'h0000, 16'h0000, 8'h5A, 1'b1);
		issue(OP_JUMP_Z,   16'h0000, 16'h1234, 8'h00, 1'b0);
		issue(OP_PTR_UP,   16'h0001, 16'h0000, 8'h00, 1'b0);
		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_PTR_UP,   16'h7FFF, 16'h0000, 8'h00, 1'b0);
		issue(OP_ADD_BYTE, 16'h0007, 16'h0000, 8'h00, 1'b0);
		issue(OP_WRITE,    16'h0000, 16'h0000, 8'h00, 1'b0);
		issue(OP_PTR_UP,   16'h0001, 16'h0000, 8'h00, 1'b0);
		issue(OP_PTR_DOWN, 16'h8000, 16'h0000, 8'h00, 1'b0);

		for (int phase = 0; phase < 8; phase++) begin
			calm = (phase % 3 == 1);
			repeat (RANDOM_ITEMS / 8) random_instr();
		end
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS tape_machine_execute_unit");
		else
			$display("FAIL tape_machine_execute_unit");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL tape_machine_execute_unit");
		$finish;
	end

endmodule
